[hdl/phcc_pkg.sv]
// Shared types, constants and the ones' complement adder for the header parser.
package phcc_pkg;

  localparam int unsigned POS_W     = 14;
  localparam logic [POS_W-1:0] HDR_BYTES = POS_W'(14);
  localparam logic [POS_W-1:0] CSUM_POS  = POS_W'(11);
  localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         data_byte;
    logic [31:0]        source_address;
    logic [31:0]        destination_address;
    logic signed [15:0] sequence_number;
    logic [15:0]        data_length_bits;
    logic               checksum_ok;
    logic               header_short;
    logic               end_of_run;
  } result_t;

  // Up to two result words produced by one accepted byte, oldest in first.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // 16-bit ones' complement add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

[hdl/phcc_in_if.sv]
// Byte input channel: valid/ready handshake carrying one packet byte and its last flag.
interface phcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last;

  modport source (output valid, output packet_byte, output last, input ready);
  modport sink   (input valid, input packet_byte, input last, output ready);
endinterface

[hdl/phcc_out_if.sv]
// Result output channel: valid/ready handshake carrying one data or summary word.
interface phcc_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         data_byte;
  logic [31:0]        source_address;
  logic [31:0]        destination_address;
  logic signed [15:0] sequence_number;
  logic [15:0]        data_length_bits;
  logic               checksum_ok;
  logic               header_short;
  logic               end_of_run;

  modport source (output valid, output kind, output data_byte, output source_address,
                  output destination_address, output sequence_number,
                  output data_length_bits, output checksum_ok, output header_short,
                  output end_of_run, input ready);
  modport sink   (input valid, input kind, input data_byte, input source_address,
                  input destination_address, input sequence_number,
                  input data_length_bits, input checksum_ok, input header_short,
                  input end_of_run, output ready);
endinterface

[hdl/phcc_parse.sv]
// Per-byte parser: header capture, checksum accumulation, payload and summary words.
module phcc_parse
  import phcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] packet_byte,
  input  logic       last,
  output push_t      push
);

  logic [POS_W-1:0] pos;
  logic [15:0]      run_sum;
  logic [7:0]       pend_hi;
  logic             pend_vld;
  logic [31:0]      src;
  logic [31:0]      dst;
  logic [15:0]      seq;
  logic [15:0]      rcsum;
  logic [15:0]      len;

  logic [POS_W-1:0] pos_next;
  logic [15:0]      run_sum_next;
  logic [7:0]       pend_hi_next;
  logic             pend_vld_next;
  logic [31:0]      src_next;
  logic [31:0]      dst_next;
  logic [15:0]      seq_next;
  logic [15:0]      rcsum_next;
  logic [15:0]      len_next;

  logic [15:0]      word;
  logic [15:0]      addend;
  logic [15:0]      sum_add;
  logic [POS_W-1:0] pay_off;
  logic [16:0]      bit_off;
  logic [15:0]      rem;
  logic [7:0]       pay_val;
  logic             emit;
  logic             shrt;
  logic             ok;
  result_t          data_res;
  result_t          sum_res;

  // Header field capture, shifting bytes in from the right
  always_comb begin
    src_next   = src;
    dst_next   = dst;
    seq_next   = seq;
    rcsum_next = rcsum;
    len_next   = len;
    if (pos < POS_W'(4)) begin
      src_next = {src[23:0], packet_byte};
    end else if (pos < POS_W'(8)) begin
      dst_next = {dst[23:0], packet_byte};
    end else if (pos < POS_W'(10)) begin
      seq_next = {seq[7:0], packet_byte};
    end else if (pos < POS_W'(12)) begin
      rcsum_next = {rcsum[7:0], packet_byte};
    end else if (pos < HDR_BYTES) begin
      len_next = {len[7:0], packet_byte};
    end
  end

  // Word pairing; one adder serves both the pair add and the odd trailing byte
  always_comb begin
    word   = (pos == CSUM_POS) ? 16'h0000 : {pend_hi, packet_byte};
    addend = pend_vld ? word : {8'h00, packet_byte};
    sum_add = oc_add(run_sum, addend);
    if (pend_vld) begin
      run_sum_next  = sum_add;
      pend_hi_next  = 8'h00;
      pend_vld_next = 1'b0;
    end else begin
      run_sum_next  = run_sum;
      pend_hi_next  = packet_byte;
      pend_vld_next = 1'b1;
    end
    pos_next = (pos == POS_MAX) ? pos : pos + POS_W'(1);
  end

  // Payload emission, trimming a partial final byte
  always_comb begin
    pay_off = pos - HDR_BYTES;
    bit_off = {pay_off, 3'b000};
    rem     = len - bit_off[15:0];
    emit    = (pos >= HDR_BYTES) && (pos != POS_MAX) && (bit_off < {1'b0, len});
    pay_val = (rem >= 16'd8) ? packet_byte : (packet_byte >> (4'd8 - rem[3:0]));
  end

  // Summary: sum_add already holds the final sum whenever it is used
  always_comb begin
    shrt = pos < (HDR_BYTES - POS_W'(1));
    ok   = !shrt && ((~sum_add) == rcsum_next);

    data_res            = '0;
    data_res.kind       = KIND_DATA;
    data_res.data_byte  = pay_val;
    data_res.end_of_run = !last;

    sum_res                     = '0;
    sum_res.kind                = KIND_SUMMARY;
    sum_res.source_address      = src_next;
    sum_res.destination_address = dst_next;
    sum_res.sequence_number     = seq_next;
    sum_res.data_length_bits    = len_next;
    sum_res.checksum_ok         = ok;
    sum_res.header_short        = shrt;
    sum_res.end_of_run          = 1'b1;
  end

  // Compact the results of this byte into the push word
  always_comb begin
    push        = '0;
    push.first  = emit ? data_res : sum_res;
    push.second = sum_res;
    if (take) begin
      push.count = {1'b0, emit} + {1'b0, last};
    end
  end

  // State update; the last byte returns everything to the reset state
  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      pos      <= '0;
      run_sum  <= '0;
      pend_hi  <= '0;
      pend_vld <= 1'b0;
      src      <= '0;
      dst      <= '0;
      seq      <= '0;
      rcsum    <= '0;
      len      <= '0;
    end else if (take) begin
      pos      <= pos_next;
      run_sum  <= run_sum_next;
      pend_hi  <= pend_hi_next;
      pend_vld <= pend_vld_next;
      src      <= src_next;
      dst      <= dst_next;
      seq      <= seq_next;
      rcsum    <= rcsum_next;
      len      <= len_next;
    end
  end

  a_pos_cleared_after_last: assert property (@(posedge clk) disable iff (rst)
    take && last |=> pos == '0 && !pend_vld && run_sum == 16'h0000)
    else $error("state not cleared after last byte");

  a_pair_bit_tracks_pos: assert property (@(posedge clk) disable iff (rst)
    (pos != POS_MAX) |-> (pend_vld == pos[0]))
    else $error("pairing bit out of step with byte position");

  a_short_never_ok: assert property (@(posedge clk) disable iff (rst)
    take && last && shrt |-> !ok)
    else $error("short header reported checksum ok");

endmodule

[hdl/phcc_outq.sv]
// Output result queue: takes up to two words per cycle, presents one per cycle.
module phcc_outq
  import phcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_word
);

  result_t           slots [QDEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign out_valid = count != '0;
  assign out_word  = slots[head];
  assign pop       = out_valid && out_ready;
  // Space for the worst case of two words from one byte
  assign room      = count <= QCNT_W'(QDEPTH - 2);

  // Storage writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[tail] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[tail + QPTR_W'(1)] <= push.second;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + QPTR_W'(push.count);
      head  <= head + QPTR_W'(pop);
      count <= count + QCNT_W'(push.count) - QCNT_W'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("push without room");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    pop && push.count == 2'd0 |=> count == $past(count) - QCNT_W'(1))
    else $error("pop did not reduce fill level");

endmodule

[hdl/packet_header_parse_checksum_check.sv]
// Top level: packet header parser with 16-bit ones' complement checksum check.
// Each result word is written into the result queue and offered from there.
// Throughput: one byte per cycle; a last byte that also carries payload yields two
// words, and the four-entry result queue holds ready low while it holds more than two.
// Reset (rst, synchronous) clears the parser state and empties the result queue.
module packet_header_parse_checksum_check
  import phcc_pkg::*;
(
  input logic         clk,
  input logic         rst,
  phcc_in_if.sink     pkt,
  phcc_out_if.source  res
);

  logic    take;
  logic    room;
  push_t   push;
  result_t out_word;

  assign pkt.ready = room;
  assign take      = pkt.valid && room;

  phcc_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .packet_byte (pkt.packet_byte),
    .last        (pkt.last),
    .push        (push)
  );

  phcc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_word  (out_word)
  );

  // Result word onto the output channel
  assign res.kind                = out_word.kind;
  assign res.data_byte           = out_word.data_byte;
  assign res.source_address      = out_word.source_address;
  assign res.destination_address = out_word.destination_address;
  assign res.sequence_number     = out_word.sequence_number;
  assign res.data_length_bits    = out_word.data_length_bits;
  assign res.checksum_ok         = out_word.checksum_ok;
  assign res.header_short        = out_word.header_short;
  assign res.end_of_run          = out_word.end_of_run;

endmodule

[verif/packet_header_parse_checksum_check_tb.sv]
// Testbench for the packet header parser and ones' complement checksum checker.
module packet_header_parse_checksum_check_tb;
  import phcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int RAND_BYTES  = 1400;
  localparam int CALM_BYTES  = 1250;

  // One row of the directed table: a byte, its last flag, and an optional typed result
  typedef struct {
    logic [7:0] b;
    logic       l;
    logic       typed;
    result_t    want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  phcc_in_if  pkt_ch ();
  phcc_out_if res_ch ();

  packet_header_parse_checksum_check i_dut (
    .clk (clk),
    .rst (rst),
    .pkt (pkt_ch),
    .res (res_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  // Parser state mirror
  int          hdr_pos;
  logic [15:0] word_sum;
  logic [7:0]  hi_byte;
  logic        hi_held;
  logic [31:0] hdr_src;
  logic [31:0] hdr_dst;
  logic [15:0] hdr_seq;
  logic [15:0] hdr_csum;
  logic [15:0] hdr_len;

  result_t step_words[$];
  result_t parser_words[$];
  logic [7:0] frame[$];
  row_t plan[$];

  int   error_count = 0;
  int   bytes_sent = 0;
  int   rand_bytes = 0;
  int   packets_sent = 0;
  int   data_seen = 0;
  int   summaries_seen = 0;
  int   good_sums = 0;
  int   short_seen = 0;
  int   cycle_count = 0;
  int   gap_pct = 10;
  int   stall_pct = 10;
  int   hold_left = 0;
  logic calm = 1'b0;

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 40) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? s[15:0] + 16'd1 : s[15:0];
  endfunction

  function automatic void clear_parser();
    hdr_pos  = 0;
    word_sum = '0;
    hi_byte  = '0;
    hi_held  = 1'b0;
    hdr_src  = '0;
    hdr_dst  = '0;
    hdr_seq  = '0;
    hdr_csum = '0;
    hdr_len  = '0;
  endfunction

  // Advance the parser by one byte; the words it produces land in step_words
  function automatic void parse_byte(input logic [7:0] b, input logic l);
    int          at;
    int          off;
    int          rem;
    logic [15:0] total;
    logic        shrt;
    result_t     r;
    step_words.delete();
    at = hdr_pos;

    // header field capture, shifted in from the right
    if (at < 4) hdr_src = {hdr_src[23:0], b};
    else if (at < 8) hdr_dst = {hdr_dst[23:0], b};
    else if (at < 10) hdr_seq = {hdr_seq[7:0], b};
    else if (at < 12) hdr_csum = {hdr_csum[7:0], b};
    else if (at < int'(HDR_BYTES)) hdr_len = {hdr_len[7:0], b};

    // pair bytes into big-endian words; the checksum word counts as zero
    if (!hi_held) begin
      hi_byte = b;
      hi_held = 1'b1;
    end else begin
      word_sum = ones_add(word_sum, (at == int'(CSUM_POS)) ? 16'h0000 : {hi_byte, b});
      hi_held  = 1'b0;
      hi_byte  = '0;
    end

    // payload inside the declared length; a partial byte keeps its leading bits
    if (at >= int'(HDR_BYTES) && at < int'(POS_MAX)) begin
      off = (at - int'(HDR_BYTES)) * 8;
      if (off < int'(hdr_len)) begin
        rem = int'(hdr_len) - off;
        r = '0;
        r.kind = KIND_DATA;
        r.data_byte = (rem >= 8) ? b : b >> (8 - rem);
        r.end_of_run = !l;
        step_words.insert(step_words.size(), r);
      end
    end

    if (hdr_pos < int'(POS_MAX)) hdr_pos++;

    // end of packet summary, odd trailing byte added right-aligned
    if (l) begin
      total = word_sum;
      shrt = (at + 1) < int'(HDR_BYTES);
      if (hi_held) total = ones_add(total, {8'h00, hi_byte});
      r = '0;
      r.kind = KIND_SUMMARY;
      r.source_address = hdr_src;
      r.destination_address = hdr_dst;
      r.sequence_number = hdr_seq;
      r.data_length_bits = hdr_len;
      r.checksum_ok = !shrt && ((~total) == hdr_csum);
      r.header_short = shrt;
      r.end_of_run = 1'b1;
      step_words.insert(step_words.size(), r);
      clear_parser();
    end
  endfunction

  function automatic result_t short_summary(input logic [31:0] src);
    result_t r;
    r = '0;
    r.kind = KIND_SUMMARY;
    r.source_address = src;
    r.header_short = 1'b1;
    r.end_of_run = 1'b1;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic l, input logic typed,
                                  input result_t want);
    row_t row;
    row.b = b;
    row.l = l;
    row.typed = typed;
    row.want = want;
    plan.insert(plan.size(), row);
  endfunction

  // Offer one byte, with an occasional idle burst ahead of it, until it is taken
  task automatic drive_byte(input logic [7:0] b, input logic l);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      pkt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    pkt_ch.valid <= 1'b1;
    pkt_ch.packet_byte <= b;
    pkt_ch.last <= l;
    @(posedge clk);
    while (pkt_ch.ready !== 1'b1) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                           input result_t want);
    drive_byte(b, l);
    parse_byte(b, l);
    if (typed) parser_words.insert(parser_words.size(), want);
    else foreach (step_words[k]) parser_words.insert(parser_words.size(), step_words[k]);
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1, 1'b0, '0);
    packets_sent++;
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_header(input logic [31:0] src, input logic [31:0] dst,
                                      input logic [15:0] seq, input logic [15:0] len);
    int i;
    frame.delete();
    for (i = 3; i >= 0; i--) frame.insert(frame.size(), src[8*i +: 8]);
    for (i = 3; i >= 0; i--) frame.insert(frame.size(), dst[8*i +: 8]);
    frame.insert(frame.size(), seq[15:8]);
    frame.insert(frame.size(), seq[7:0]);
    frame.insert(frame.size(), 8'($urandom_range(0, 255)));
    frame.insert(frame.size(), 8'($urandom_range(0, 255)));
    frame.insert(frame.size(), len[15:8]);
    frame.insert(frame.size(), len[7:0]);
  endfunction

  // Store the complement of the frame's ones' complement sum in the checksum field
  function automatic void seal_frame();
    logic [15:0] acc;
    int          i;
    acc = '0;
    for (i = 0; i < frame.size(); i += 2) begin
      if (i != 10) begin
        if (i + 1 < frame.size()) acc = ones_add(acc, {frame[i], frame[i+1]});
        else acc = ones_add(acc, {8'h00, frame[i]});
      end
    end
    acc = ~acc;
    frame[10] = acc[15:8];
    frame[11] = acc[7:0];
  endfunction

  // Mostly well-formed packets, otherwise short headers or plain noise
  function automatic void build_packet();
    int          r;
    int          full;
    int          pay_n;
    int          i;
    logic [15:0] seq;
    logic [15:0] len;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       seq = 16'h8000;
        1:       seq = 16'h7FFF;
        default: seq = 16'($urandom_range(0, 65535));
      endcase
      r = $urandom_range(0, 99);
      if (r < 6) len = 16'h0000;
      else if (r < 12) len = 16'hFFFF;
      else if (r < 20) len = 16'($urandom_range(0, 65535));
      else len = 16'($urandom_range(1, 96));
      full = (int'(len) + 7) / 8;
      if (full > 12) full = 12;
      if ($urandom_range(0, 3) == 0) pay_n = $urandom_range(0, full);
      else pay_n = full + $urandom_range(0, 2);
      push_header(pick32(), pick32(), seq, len);
      for (i = 0; i < pay_n; i++) frame.insert(frame.size(), 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) != 0) seal_frame();
    end else begin
      pay_n = (r < 88) ? $urandom_range(1, int'(HDR_BYTES)) : $urandom_range(1, 30);
      frame.delete();
      for (i = 0; i < pay_n; i++) frame.insert(frame.size(), 8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic run_random(input int upto);
    while (rand_bytes < upto) begin
      calm = (rand_bytes >= CALM_BYTES);
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 8;
        default: gap_pct = 30;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 8;
        default: stall_pct = 30;
      endcase
      build_packet();
      rand_bytes += frame.size();
      send_frame();
    end
  endtask

  // Result sink: ready drops in random bursts, none in the final stretch
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && hold_left == 0 && $urandom_range(0, 99) < stall_pct)
        hold_left = $urandom_range(1, 18);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic compare_word(input result_t got, input result_t want);
    int n;
    n = data_seen + summaries_seen;
    if (got.kind !== want.kind)
      report_error($sformatf("word %0d kind: got %0d want %0d", n, got.kind, want.kind));
    if (got.data_byte !== want.data_byte)
      report_error($sformatf("word %0d data_byte: got %h want %h", n, got.data_byte,
                             want.data_byte));
    if (got.source_address !== want.source_address)
      report_error($sformatf("word %0d source_address: got %h want %h", n,
                             got.source_address, want.source_address));
    if (got.destination_address !== want.destination_address)
      report_error($sformatf("word %0d destination_address: got %h want %h", n,
                             got.destination_address, want.destination_address));
    if (got.sequence_number !== want.sequence_number)
      report_error($sformatf("word %0d sequence_number: got %0d want %0d", n,
                             got.sequence_number, want.sequence_number));
    if (got.data_length_bits !== want.data_length_bits)
      report_error($sformatf("word %0d data_length_bits: got %h want %h", n,
                             got.data_length_bits, want.data_length_bits));
    if (got.checksum_ok !== want.checksum_ok)
      report_error($sformatf("word %0d checksum_ok: got %b want %b", n, got.checksum_ok,
                             want.checksum_ok));
    if (got.header_short !== want.header_short)
      report_error($sformatf("word %0d header_short: got %b want %b", n, got.header_short,
                             want.header_short));
    if (got.end_of_run !== want.end_of_run)
      report_error($sformatf("word %0d end_of_run: got %b want %b", n, got.end_of_run,
                             want.end_of_run));
  endtask

  // Check every accepted result word against the oldest one the parser owes
  always @(posedge clk) begin : watch_results
    result_t got;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got.kind                = kind_t'(res_ch.kind);
      got.data_byte           = res_ch.data_byte;
      got.source_address      = res_ch.source_address;
      got.destination_address = res_ch.destination_address;
      got.sequence_number     = res_ch.sequence_number;
      got.data_length_bits    = res_ch.data_length_bits;
      got.checksum_ok         = res_ch.checksum_ok;
      got.header_short        = res_ch.header_short;
      got.end_of_run          = res_ch.end_of_run;
      if (parser_words.size() == 0) begin
        report_error($sformatf("word with nothing owed, kind %0d", got.kind));
      end else begin
        compare_word(got, parser_words.pop_front());
      end
      if (got.kind == KIND_DATA) begin
        data_seen++;
      end else begin
        summaries_seen++;
        if (got.checksum_ok === 1'b1) good_sums++;
        if (got.header_short === 1'b1) short_seen++;
      end
    end
  end

  // Cycle limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : main_flow
    pkt_ch.valid <= 1'b0;
    pkt_ch.packet_byte <= 8'h00;
    pkt_ch.last <= 1'b0;
    clear_parser();

    // Directed: one-byte packets at both extremes, a two-byte short header,
    // then a full header with minimum sequence, partial last payload byte,
    // a byte past the declared length and a matching checksum.
    add_row(8'hFF, 1'b1, 1'b1, short_summary(32'h0000_00FF));
    add_row(8'h00, 1'b1, 1'b1, short_summary(32'h0000_0000));
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b1, 1'b1, short_summary(32'h0000_8001));
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'hE7, 1'b0, 1'b0, '0);
    add_row(8'h18, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h14, 1'b0, 1'b0, '0);
    add_row(8'hA5, 1'b0, 1'b0, '0);
    add_row(8'h5A, 1'b0, 1'b0, '0);
    add_row(8'hF3, 1'b0, 1'b0, '0);
    add_row(8'h77, 1'b1, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_byte(plan[i].b, plan[i].l, plan[i].typed, plan[i].want);
    packets_sent += 4;

    run_random(RAND_BYTES);
    pkt_ch.valid <= 1'b0;

    while (parser_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run sent %0d bytes in %0d packets: directed headers, then random frames",
             bytes_sent, packets_sent);
    $display("Checked %0d data words and %0d summaries (%0d good checksums, %0d short)",
             data_seen, summaries_seen, good_sums, short_seen);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/phcc_pkg.sv
hdl/phcc_in_if.sv
hdl/phcc_out_if.sv
hdl/phcc_parse.sv
hdl/phcc_outq.sv
hdl/packet_header_parse_checksum_check.sv
verif/packet_header_parse_checksum_check_tb.sv
